[rtl/sorted_interval_overlap_join_top_assert.svh]
// Assertion macros for the sorted interval overlap join RTL.
`ifndef SORTED_INTERVAL_OVERLAP_JOIN_TOP_ASSERT_SVH
`define SORTED_INTERVAL_OVERLAP_JOIN_TOP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define SIOJ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define SIOJ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/sioj_pkg.sv]
// Types, widths and codes shared by the sorted interval overlap join.
package sioj_pkg;

  localparam int CoordBits = 30;
  localparam int ChromBits = 16;
  localparam int TagBits   = 32;

  localparam int DistBits = CoordBits + 1;
  localparam int CalcBits = CoordBits + 2;

  localparam int OpBits     = 2;
  localparam int StatusBits = 2;

  localparam int InStartLsb  = ChromBits;
  localparam int InEndLsb    = ChromBits + CoordBits;
  localparam int InTagLsb    = ChromBits + 2 * CoordBits;
  localparam int InUsedBits  = ChromBits + 2 * CoordBits + TagBits;
  localparam int InDataBits  = ((InUsedBits + 7) / 8) * 8;
  localparam int OutUsedBits = 1 + TagBits + DistBits;
  localparam int OutDataBits = ((OutUsedBits + 7) / 8) * 8;

  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = CoordBits;

  localparam logic signed [CalcBits-1:0] CalcMinusOne = CalcBits'(-1);
  localparam logic signed [CalcBits-1:0] CalcOne      = CalcBits'(1);

  typedef enum logic [OpBits-1:0] {
    OpDbRegion = 2'd0,
    OpDbEnd    = 2'd1,
    OpQuery    = 2'd2
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    StNeedNext = 2'd0,
    StAnswered = 2'd1,
    StNothing  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgNearEnable = 1'b0,
    CfgNearLimit  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [OpBits-1:0]    op;
    logic [ChromBits-1:0] chrom;
    logic [CoordBits-1:0] region_start;
    logic [CoordBits-1:0] region_end;
    logic [TagBits-1:0]   tag;
  } item_t;

  typedef struct packed {
    status_e                     status;
    logic                        hit;
    logic [TagBits-1:0]          match_tag;
    logic signed [DistBits-1:0]  distance;
  } res_t;

endpackage

[rtl/sioj_in_reg.sv]
// Input register: holds one accepted word until the join core takes it.
module sioj_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sioj_pkg::item_t     item_i,
  input  logic                pop_i,
  output logic                ready_o,
  output logic                valid_o,
  output sioj_pkg::item_t     item_o
);

  logic            valid_q, valid_d;
  sioj_pkg::item_t item_q;

  assign ready_o = !valid_q || pop_i;
  assign valid_d = push_i || (valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/sioj_core.sv]
// Join core: database and query state, evaluation of one word per cycle while step_i is high.
`include "sorted_interval_overlap_join_top_assert.svh"

module sioj_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sioj_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [sioj_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  input  logic                              step_i,
  input  sioj_pkg::item_t                   item_i,
  output sioj_pkg::res_t                    res_o
);

  logic                                near_enable_q;
  logic [sioj_pkg::CoordBits-1:0]      near_limit_q;

  logic                                cur_valid_q, cur_valid_d;
  logic [sioj_pkg::ChromBits-1:0]      cur_chrom_q, cur_chrom_d;
  logic [sioj_pkg::CoordBits-1:0]      cur_start_q, cur_start_d;
  logic [sioj_pkg::CoordBits-1:0]      cur_end_q, cur_end_d;
  logic [sioj_pkg::TagBits-1:0]        cur_tag_q, cur_tag_d;
  logic                                db_done_q, db_done_d;
  logic                                keep_valid_q, keep_valid_d;
  logic [sioj_pkg::ChromBits-1:0]      keep_chrom_q, keep_chrom_d;
  logic [sioj_pkg::CoordBits-1:0]      keep_end_q, keep_end_d;
  logic [sioj_pkg::TagBits-1:0]        keep_tag_q, keep_tag_d;
  logic                                query_pending_q, query_pending_d;
  logic [sioj_pkg::ChromBits-1:0]      q_chrom_q, q_chrom_d;
  logic [sioj_pkg::CoordBits-1:0]      q_start_q, q_start_d;
  logic [sioj_pkg::CoordBits-1:0]      q_end_q, q_end_d;

  always_comb begin
    logic                                  do_eval;
    logic                                  cur_before;
    logic                                  wait_db;
    logic                                  same_cur;
    logic                                  same_keep;
    logic                                  overlap;
    logic signed [sioj_pkg::CalcBits-1:0]  gap_a;
    logic signed [sioj_pkg::CalcBits-1:0]  gap_b;
    logic signed [sioj_pkg::CalcBits-1:0]  gap_keep;
    logic signed [sioj_pkg::CalcBits-1:0]  limit_s;
    logic signed [sioj_pkg::CalcBits-1:0]  near;
    logic [sioj_pkg::TagBits-1:0]          near_tag;

    cur_valid_d     = cur_valid_q;
    cur_chrom_d     = cur_chrom_q;
    cur_start_d     = cur_start_q;
    cur_end_d       = cur_end_q;
    cur_tag_d       = cur_tag_q;
    db_done_d       = db_done_q;
    keep_valid_d    = keep_valid_q;
    keep_chrom_d    = keep_chrom_q;
    keep_end_d      = keep_end_q;
    keep_tag_d      = keep_tag_q;
    query_pending_d = query_pending_q;
    q_chrom_d       = q_chrom_q;
    q_start_d       = q_start_q;
    q_end_d         = q_end_q;
    do_eval         = 1'b0;

    res_o.status    = sioj_pkg::StNothing;
    res_o.hit       = 1'b0;
    res_o.match_tag = '0;
    res_o.distance  = '0;

    case (item_i.op)
      sioj_pkg::OpDbRegion: begin
        // Regions that arrive after the end marker are dropped.
        if (!db_done_q) begin
          if (cur_valid_q) begin
            keep_valid_d = 1'b1;
            keep_chrom_d = cur_chrom_q;
            keep_end_d   = cur_end_q;
            keep_tag_d   = cur_tag_q;
          end
          cur_valid_d = 1'b1;
          cur_chrom_d = item_i.chrom;
          cur_start_d = item_i.region_start;
          cur_end_d   = item_i.region_end;
          cur_tag_d   = item_i.tag;
          do_eval     = query_pending_q;
        end
      end
      sioj_pkg::OpDbEnd: begin
        db_done_d = 1'b1;
        do_eval   = query_pending_q;
      end
      sioj_pkg::OpQuery: begin
        query_pending_d = 1'b1;
        q_chrom_d       = item_i.chrom;
        q_start_d       = item_i.region_start;
        q_end_d         = item_i.region_end;
        do_eval         = 1'b1;
      end
      default: begin
      end
    endcase

    cur_before = cur_valid_d && ((cur_chrom_d < q_chrom_d) ||
                 ((cur_chrom_d == q_chrom_d) && (cur_end_d <= q_start_d)));
    wait_db = !db_done_d && (cur_before || !cur_valid_d);

    // Once the database has ended, a region wholly before the query retires
    // into the kept slot so that the query can still be answered.
    if (do_eval && cur_before && db_done_d) begin
      keep_valid_d = 1'b1;
      keep_chrom_d = cur_chrom_d;
      keep_end_d   = cur_end_d;
      keep_tag_d   = cur_tag_d;
      cur_valid_d  = 1'b0;
    end

    same_cur  = cur_valid_d && (cur_chrom_d == q_chrom_d);
    same_keep = keep_valid_d && (keep_chrom_d == q_chrom_d);
    overlap   = same_cur && (q_end_d > cur_start_d);

    gap_a = $signed({2'b00, q_end_d}) - $signed({2'b00, cur_end_d});
    gap_b = $signed({2'b00, cur_start_d}) - $signed({2'b00, q_start_d}) - sioj_pkg::CalcOne;
    if (!gap_a[sioj_pkg::CalcBits-1]) begin
      gap_a = sioj_pkg::CalcMinusOne;
    end
    if (!gap_b[sioj_pkg::CalcBits-1]) begin
      gap_b = sioj_pkg::CalcMinusOne;
    end

    limit_s  = $signed({2'b00, near_limit_q});
    gap_keep = $signed({2'b00, q_start_d}) - $signed({2'b00, keep_end_d});
    near     = limit_s;
    near_tag = '0;
    if (same_cur) begin
      near     = $signed({2'b00, cur_start_d}) - $signed({2'b00, q_end_d});
      near_tag = cur_tag_d;
    end
    // A tie keeps the current region.
    if (same_keep && (gap_keep < near)) begin
      near     = gap_keep;
      near_tag = keep_tag_d;
    end

    if (do_eval) begin
      if (wait_db) begin
        res_o.status = sioj_pkg::StNeedNext;
      end else begin
        res_o.status    = sioj_pkg::StAnswered;
        query_pending_d = 1'b0;
        if (overlap) begin
          res_o.hit       = 1'b1;
          res_o.match_tag = cur_tag_d;
          if (near_enable_q) begin
            res_o.distance = (gap_b > gap_a) ? gap_b[sioj_pkg::DistBits-1:0]
                                             : gap_a[sioj_pkg::DistBits-1:0];
          end
        end else if (near_enable_q && (near < limit_s)) begin
          res_o.hit       = 1'b1;
          res_o.match_tag = near_tag;
          res_o.distance  = near[sioj_pkg::DistBits-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_enable_q <= 1'b0;
      near_limit_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sioj_pkg::CfgNearEnable: near_enable_q <= cfg_wdata_i[0];
        sioj_pkg::CfgNearLimit:  near_limit_q  <= cfg_wdata_i[sioj_pkg::CoordBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q     <= 1'b0;
      cur_chrom_q     <= '0;
      cur_start_q     <= '0;
      cur_end_q       <= '0;
      cur_tag_q       <= '0;
      db_done_q       <= 1'b0;
      keep_valid_q    <= 1'b0;
      keep_chrom_q    <= '0;
      keep_end_q      <= '0;
      keep_tag_q      <= '0;
      query_pending_q <= 1'b0;
      q_chrom_q       <= '0;
      q_start_q       <= '0;
      q_end_q         <= '0;
    end else if (step_i) begin
      cur_valid_q     <= cur_valid_d;
      cur_chrom_q     <= cur_chrom_d;
      cur_start_q     <= cur_start_d;
      cur_end_q       <= cur_end_d;
      cur_tag_q       <= cur_tag_d;
      db_done_q       <= db_done_d;
      keep_valid_q    <= keep_valid_d;
      keep_chrom_q    <= keep_chrom_d;
      keep_end_q      <= keep_end_d;
      keep_tag_q      <= keep_tag_d;
      query_pending_q <= query_pending_d;
      q_chrom_q       <= q_chrom_d;
      q_start_q       <= q_start_d;
      q_end_q         <= q_end_d;
    end
  end

  `SIOJ_ASSERT(a_need_next_keeps_query, step_i && (res_o.status == sioj_pkg::StNeedNext) |=> query_pending_q, "query lost while waiting for the database")
  `SIOJ_ASSERT(a_answer_clears_query, step_i && (res_o.status == sioj_pkg::StAnswered) |=> !query_pending_q, "answered query still pending")
  `SIOJ_ASSERT(a_db_done_sticky, db_done_q |=> db_done_q, "end of database flag dropped")
  `SIOJ_ASSERT(a_hit_only_on_answer, step_i && res_o.hit |-> (res_o.status == sioj_pkg::StAnswered), "hit on a word that answers no query")
  `SIOJ_ASSERT_ALWAYS(a_reset_clears_state, !rst_ni |-> !query_pending_q && !db_done_q && !cur_valid_q, "state not cleared in reset")

endmodule

[rtl/sioj_out_reg.sv]
// Result register: holds one result word until the downstream side takes it.
module sioj_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sioj_pkg::res_t  res_i,
  input  logic            pop_i,
  output logic            ready_o,
  output logic            valid_o,
  output sioj_pkg::res_t  res_o
);

  logic           valid_q, valid_d;
  sioj_pkg::res_t res_q;

  assign ready_o = !valid_q || pop_i;
  assign valid_d = push_i || (valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[rtl/sorted_interval_overlap_join_top.sv]
// Top level of the sorted interval overlap join.
//
//   Channel  Dir  Carries
//   s_axis   in   tuser: operation; tdata: chrom, region_start, region_end, tag
//   m_axis   out  tuser: status; tdata: hit, match_tag, distance
//   cfg      in   cfg_idx_i 0 near_enable, 1 near_limit; write-only
//
// One word is accepted per cycle while m_axis does not stall, and every word
// gives exactly one result word. A word passes the input register, then the
// join core, which updates its state and loads the result register in the
// same cycle. The rate is set by the single evaluation stage of the core.
// rst_ni clears all state and both registers; there is no clearing pass.
// A stalled m_axis holds the result word and backpressures s_axis through the input register.
module sorted_interval_overlap_join_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sioj_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [sioj_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // chrom, region_start, region_end, tag, zero fill
  input  logic [sioj_pkg::InDataBits-1:0]    s_axis_tdata,
  // operation
  input  logic [sioj_pkg::OpBits-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit, match_tag, distance
  output logic [sioj_pkg::OutDataBits-1:0]   m_axis_tdata,
  // status
  output logic [sioj_pkg::StatusBits-1:0]    m_axis_tuser
);

  sioj_pkg::item_t in_item;
  sioj_pkg::item_t core_item;
  sioj_pkg::res_t  core_res;
  sioj_pkg::res_t  out_res;
  logic            in_push;
  logic            in_valid;
  logic            out_ready;
  logic            step;

  assign in_item.op           = s_axis_tuser;
  assign in_item.chrom        = s_axis_tdata[sioj_pkg::ChromBits-1:0];
  assign in_item.region_start =
      s_axis_tdata[sioj_pkg::InStartLsb +: sioj_pkg::CoordBits];
  assign in_item.region_end   =
      s_axis_tdata[sioj_pkg::InEndLsb +: sioj_pkg::CoordBits];
  assign in_item.tag          =
      s_axis_tdata[sioj_pkg::InTagLsb +: sioj_pkg::TagBits];

  assign in_push = s_axis_tvalid && s_axis_tready;
  assign step    = in_valid && out_ready;

  sioj_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_push),
    .item_i  (in_item),
    .pop_i   (step),
    .ready_o (s_axis_tready),
    .valid_o (in_valid),
    .item_o  (core_item)
  );

  sioj_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (core_item),
    .res_o       (core_res)
  );

  sioj_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .res_i   (core_res),
    .pop_i   (m_axis_tready),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = sioj_pkg::OutDataBits'({out_res.distance, out_res.match_tag,
                                                out_res.hit});
  assign m_axis_tuser = out_res.status;

endmodule

[tb/sioj_join_checker.sv]
// Checker for the interval join: predicts every result word and compares it on arrival.
module sioj_join_checker
  import sioj_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // chrom, region_start, region_end, tag, zero fill
  input  logic [InDataBits-1:0]  s_axis_tdata,
  // operation
  input  logic [OpBits-1:0]      s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit, match_tag, distance
  input  logic [OutDataBits-1:0] m_axis_tdata,
  // status
  input  logic [StatusBits-1:0]  m_axis_tuser,
  output int                     fail_count_o,
  output int                     waiting_o,
  output int                     checked_o,
  output int                     answered_o,
  output int                     hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OutTagLsb  = 1;
  localparam int OutDistLsb = 1 + TagBits;

  typedef logic signed [CalcBits-1:0] calc_t;

  logic                 near_on;
  logic [CoordBits-1:0] near_cap;
  logic                 cur_ok, db_closed, keep_ok, q_waiting;
  logic [ChromBits-1:0] cur_chr, keep_chr, q_chr;
  logic [CoordBits-1:0] cur_lo, cur_hi, keep_hi, q_lo, q_hi;
  logic [TagBits-1:0]   cur_label, keep_label;
  res_t                 due_answers[$];
  int                   errs, checked, answered, hits;

  function automatic calc_t widen(input logic [CoordBits-1:0] v);
    return $signed({2'b00, v});
  endfunction

  function automatic void retire_current();
    keep_ok    = 1'b1;
    keep_chr   = cur_chr;
    keep_hi    = cur_hi;
    keep_label = cur_label;
  endfunction

  function automatic res_t judge_query();
    res_t  r;
    calc_t over_end, over_start, gap, side;
    r = '0;
    r.status = StNeedNext;
    if (cur_ok && (cur_chr < q_chr || (cur_chr == q_chr && cur_hi <= q_lo))) begin
      if (!db_closed) return r;
      // Nothing more will come, so the passed region becomes the left neighbor.
      retire_current();
      cur_ok = 1'b0;
    end
    if (!cur_ok && !db_closed) return r;
    q_waiting = 1'b0;
    r.status = StAnswered;
    if (cur_ok && cur_chr == q_chr && q_hi > cur_lo) begin
      r.hit = 1'b1;
      r.match_tag = cur_label;
      if (near_on) begin
        // Depth is negative; the shallower of the two sides is reported.
        over_end   = widen(q_hi) - widen(cur_hi);
        over_start = widen(cur_lo) - widen(q_lo) - CalcOne;
        if (over_end >= 0) over_end = CalcMinusOne;
        if (over_start >= 0) over_start = CalcMinusOne;
        gap = (over_start > over_end) ? over_start : over_end;
        r.distance = gap[DistBits-1:0];
      end
    end else if (near_on) begin
      gap = widen(near_cap);
      if (cur_ok && cur_chr == q_chr) begin
        gap = widen(cur_lo) - widen(q_hi);
        r.match_tag = cur_label;
      end
      side = widen(q_lo) - widen(keep_hi);
      // On a tie the current region stays the reported one.
      if (keep_ok && keep_chr == q_chr && side < gap) begin
        gap = side;
        r.match_tag = keep_label;
      end
      if (gap >= widen(near_cap)) begin
        r.match_tag = '0;
      end else begin
        r.hit = 1'b1;
        r.distance = gap[DistBits-1:0];
      end
    end
    return r;
  endfunction

  function automatic res_t join_word(input logic [OpBits-1:0] op,
                                     input logic [ChromBits-1:0] chrom,
                                     input logic [CoordBits-1:0] lo,
                                     input logic [CoordBits-1:0] hi,
                                     input logic [TagBits-1:0] label);
    res_t r;
    r = '0;
    r.status = StNothing;
    case (op)
      OpDbRegion: begin
        if (!db_closed) begin
          if (cur_ok) retire_current();
          cur_ok    = 1'b1;
          cur_chr   = chrom;
          cur_lo    = lo;
          cur_hi    = hi;
          cur_label = label;
          if (q_waiting) r = judge_query();
        end
      end
      OpDbEnd: begin
        db_closed = 1'b1;
        if (q_waiting) r = judge_query();
      end
      OpQuery: begin
        q_waiting = 1'b1;
        q_chr = chrom;
        q_lo  = lo;
        q_hi  = hi;
        r = judge_query();
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t seen, want;
    if (!rst_ni) begin
      near_on = 1'b0;    near_cap = '0;
      cur_ok = 1'b0;     cur_chr = '0;   cur_lo = '0;  cur_hi = '0;  cur_label = '0;
      db_closed = 1'b0;
      keep_ok = 1'b0;    keep_chr = '0;  keep_hi = '0; keep_label = '0;
      q_waiting = 1'b0;  q_chr = '0;     q_lo = '0;    q_hi = '0;
      due_answers.delete();
      errs = 0; checked = 0; answered = 0; hits = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgNearEnable: near_on = cfg_wdata_i[0];
          CfgNearLimit:  near_cap = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.status    = status_e'(m_axis_tuser);
        seen.hit       = m_axis_tdata[0];
        seen.match_tag = m_axis_tdata[OutTagLsb +: TagBits];
        seen.distance  = m_axis_tdata[OutDistLsb +: DistBits];
        if (due_answers.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          errs++;
        end else begin
          want = due_answers.pop_front();
          check_field("status", 64'(want.status), 64'(seen.status));
          check_field("hit", 64'(want.hit), 64'(seen.hit));
          check_field("match_tag", 64'(want.match_tag), 64'(seen.match_tag));
          check_field("distance", 64'($unsigned(want.distance)),
                      64'($unsigned(seen.distance)));
          checked++;
          if (want.status == StAnswered) answered++;
          if (want.hit) hits++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_answers.push_back(join_word(s_axis_tuser, s_axis_tdata[ChromBits-1:0],
                                        s_axis_tdata[InStartLsb +: CoordBits],
                                        s_axis_tdata[InEndLsb +: CoordBits],
                                        s_axis_tdata[InTagLsb +: TagBits]));
      end
    end
    fail_count_o <= errs;
    waiting_o    <= due_answers.size();
    checked_o    <= checked;
    answered_o   <= answered;
    hits_o       <= hits;
  end

endmodule

[tb/tb_sorted_interval_overlap_join_top.sv]
// Testbench top for the interval join: drives reset, registers and words, gives the verdict.
module tb_sorted_interval_overlap_join_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sioj_pkg::*;

  localparam logic [OpBits-1:0]    OpReserved = 2'd3;
  localparam logic [CoordBits-1:0] CoordMax   = '1;
  localparam logic [ChromBits-1:0] ChromMax   = '1;
  localparam int IdleLimit   = 2000;
  localparam int Phases      = 13;
  localparam int PhaseWords  = 100;
  localparam int HoldCycles  = 120;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic [OpBits-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic [StatusBits-1:0]  m_axis_tuser;

  int   fail_count, waiting, checked, answered, hits;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   modes = 0;
  int   idle_cycles = 0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  sorted_interval_overlap_join_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  sioj_join_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .waiting_o    (waiting),
    .checked_o    (checked),
    .answered_o   (answered),
    .hits_o       (hits)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $error("no word moved for %0d cycles", IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold on request, always ready when quiet.
  initial begin : result_side
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if ($urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  // Entered and left at a falling edge; tvalid stays high for a following word.
  task automatic send_word(input logic [OpBits-1:0] op, input logic [ChromBits-1:0] chrom,
                           input logic [CoordBits-1:0] lo, input logic [CoordBits-1:0] hi,
                           input logic [TagBits-1:0] label);
    int n;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= InDataBits'({label, hi, lo, chrom});
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_mode(input logic enable, input logic [CoordBits-1:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgNearEnable;
    cfg_wdata_i <= CfgDataBits'(enable);
    @(negedge clk_i);
    cfg_idx_i   <= CfgNearLimit;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    modes++;
  endtask

  function automatic logic [CoordBits-1:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CoordMax - CoordBits'($urandom_range(0, 200000));
      default: return CoordBits'($urandom_range(0, 1000000));
    endcase
  endfunction

  // Two sorted streams merged by (chromosome, start), with a little disorder and noise.
  task automatic run_session(input int words, input int scale);
    logic [ChromBits-1:0] db_chr, q_chr;
    logic [CoordBits-1:0] db_pos, q_pos, lo, hi;
    logic [OpBits-1:0]    op;
    int                   sent, roll;
    db_chr = ChromBits'($urandom());
    q_chr  = db_chr;
    db_pos = pick_base();
    q_pos  = db_pos;
    sent   = 0;
    while (sent < words) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        q_chr++;
        q_pos = pick_base();
      end else if (roll < 6) begin
        db_chr++;
        db_pos = pick_base();
      end else if (roll < 12) begin
        // End of database is held back to the last part of the run.
        op = OpBits'($urandom_range(0, 3));
        if (op == OpDbEnd) op = OpReserved;
        send_word(op, ChromBits'($urandom()), CoordBits'($urandom()), CoordBits'($urandom()),
                  TagBits'($urandom()));
        sent++;
      end else if (({db_chr, db_pos} <= {q_chr, q_pos}) != (roll < 20)) begin
        lo = db_pos + CoordBits'($urandom_range(0, scale));
        hi = lo + CoordBits'($urandom_range(0, 2 * scale));
        db_pos = lo;
        send_word(OpDbRegion, db_chr, lo, hi, TagBits'($urandom()));
        sent++;
      end else begin
        lo = q_pos + CoordBits'($urandom_range(0, scale));
        hi = lo + CoordBits'($urandom_range(0, scale));
        q_pos = lo;
        send_word(OpQuery, q_chr, lo, hi, TagBits'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int                   scale;
    logic [CoordBits-1:0] lo;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgNearEnable;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpDbRegion;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Hand-picked cases in near mode with the widest limit.
    set_mode(1'b1, CoordMax);
    send_word(OpQuery,    16'd5, 30'd100, 30'd200, 32'h0);           // no region yet
    send_word(OpDbRegion, 16'd5, 30'd10,  30'd50,  32'hA000_0001);   // still before query
    send_word(OpDbRegion, 16'd5, 30'd150, 30'd300, 32'hA000_0002);   // overlap
    send_word(OpQuery,    16'd5, 30'd250, 30'd260, 32'h0);           // query inside region
    send_word(OpQuery,    16'd5, 30'd400, 30'd500, 32'h0);
    send_word(OpQuery,    16'd5, 30'd320, 30'd330, 32'h0);           // replaces pending query
    send_word(OpDbRegion, 16'd5, 30'd340, 30'd350, 32'hA000_0003);   // right neighbor closer
    send_word(OpQuery,    16'd5, 30'd360, 30'd370, 32'h0);
    send_word(OpDbRegion, 16'd6, 30'd0,   30'd10,  32'hA000_0004);   // next chromosome
    send_word(OpQuery,    16'd6, 30'd5,   30'd8,   32'h0);
    send_word(OpQuery,    16'd6, 30'd20,  30'd20,  32'h0);           // empty query
    send_word(OpDbRegion, 16'd6, 30'd30,  30'd25,  32'hA000_0005);   // inverted, tie
    send_word(OpDbRegion, ChromMax, '0, CoordMax, 32'hFFFF_FFFF);
    send_word(OpQuery,    ChromMax, CoordMax, CoordMax, 32'h0);
    send_word(OpQuery,    ChromMax, '0, CoordMax, 32'hFFFF_FFFF);
    send_word(OpQuery,    ChromMax, CoordMax - 30'd1, CoordMax, 32'h0);
    send_word(OpReserved, ChromMax, CoordMax, CoordMax, 32'hFFFF_FFFF);
    send_word(OpDbRegion, 16'd0, 30'd0, 30'd0, 32'h0);
    send_word(OpQuery,    16'd0, 30'd0, 30'd1, 32'h0);
    send_word(OpDbRegion, 16'd0, CoordMax, CoordMax, 32'h1);          // kept region wins
    send_word(OpQuery,    16'd0, 30'd0, 30'd0, 32'h0);

    for (int phase = 0; phase < Phases; phase++) begin
      case ($urandom_range(0, 3))
        0:       scale = 3;
        1:       scale = 40;
        2:       scale = 500;
        default: scale = 20000;
      endcase
      case (phase % 6)
        0:       set_mode(1'b0, CoordBits'($urandom()));
        1:       set_mode(1'b1, CoordMax);
        2:       set_mode(1'b1, '0);
        3:       set_mode(1'b1, CoordBits'($urandom_range(1, scale)));
        4:       set_mode(1'b0, CoordMax);
        default: set_mode(1'b1, CoordBits'($urandom_range(0, 3 * scale)));
      endcase
      gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(5, 50);
      stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 50);
      if (phase == Phases / 2) hold_req = 1'b1;
      run_session(PhaseWords, scale);
    end

    // Last part: no idling, and the database is closed for good.
    quiet = 1'b1;
    set_mode(1'b1, CoordBits'(1000));
    send_word(OpDbRegion, 16'd40000, 30'd100, 30'd200, 32'h0B0B_0001);
    send_word(OpQuery,    16'd40000, 30'd500, 30'd600, 32'h0);
    send_word(OpDbEnd,    16'd0, '0, '0, 32'h0);                    // answers the pending query
    send_word(OpQuery,    16'd40000, 30'd150, 30'd160, 32'h0);      // negative gap
    send_word(OpDbRegion, 16'd40000, 30'd700, 30'd800, 32'h0B0B_0002);
    send_word(OpQuery,    16'd40001, 30'd10,  30'd20,  32'h0);
    send_word(OpReserved, 16'd40000, 30'd0,   30'd0,   32'h0);
    for (int i = 0; i < 30; i++) begin
      if (i == 10) set_mode(1'b0, '0);
      if (i == 20) set_mode(1'b1, CoordMax);
      lo = CoordBits'($urandom_range(0, 3000));
      send_word(OpQuery, 16'd40000 + ChromBits'($urandom_range(0, 1)), lo,
                lo + CoordBits'($urandom_range(0, 300)), TagBits'($urandom()));
      if (i % 7 == 3)
        send_word(OpDbRegion, 16'd40000, lo, lo + 30'd5, TagBits'($urandom()));
      if (i % 11 == 5) send_word(OpDbEnd, 16'd0, '0, '0, 32'h0);
    end

    wait_drained();
    $display("Run covered %0d result words over %0d register settings: hand-picked cases,",
             checked, modes);
    $display("noisy sorted join sessions and late queries; %0d answered, %0d with a region.",
             answered, hits);
    if (fail_count == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
